FILE: hdl/twc_pkg.sv
`default_nettype none

package twc_pkg;

    localparam int FRAC_BITS = 16;

    localparam int SW_W     = 13;
    localparam int SH_W     = 12;
    localparam int TW_W     = 11;
    localparam int TH_W     = 11;
    localparam int COL_W    = 12;
    localparam int RAY_W    = 18;
    localparam int DIST_W   = 24;
    localparam int PLAYER_W = 24;
    localparam int SX_W     = 12;
    localparam int SY_W     = 11;
    localparam int TSEL_W   = 2;
    localparam int TEXEL_W  = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam int ROW_W    = SH_W;
    localparam int HEIGHT_W = 24;
    localparam int HHALF_W  = HEIGHT_W - 1;
    localparam int DIV_W    = SH_W + FRAC_BITS;
    localparam int WALL_W   = 2 * FRAC_BITS;
    localparam int STEP_W   = 32;
    localparam int POS_W    = 32;

    localparam logic [HEIGHT_W-1:0] HEIGHT_CAP = '1;
    localparam logic [STEP_W-1:0]   STEP_CAP   = '1;

    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXTURE_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXTURE_HEIGHT = 2'd3;

    localparam logic ACT_START = 1'b0;
    localparam logic ACT_TICK  = 1'b1;

    localparam logic [TSEL_W-1:0] TEX_WEST  = 2'd0;
    localparam logic [TSEL_W-1:0] TEX_EAST  = 2'd1;
    localparam logic [TSEL_W-1:0] TEX_NORTH = 2'd2;
    localparam logic [TSEL_W-1:0] TEX_SOUTH = 2'd3;

    typedef struct packed {
        logic capture;
        logic tick;
        logic tex_mul;
        logic take_height;
        logic span_calc;
        logic take_step;
        logic commit;
    } twc_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic out_stall;
    } twc_status_t;

endpackage

`default_nettype wire

FILE: hdl/textured_wall_column_core.sv
// Textured wall column of a raycaster.
// Input channel s_*: an item with s_action low starts a column (column, hit
// side, ray direction, wall distance, player position); an item with
// s_action high asks for the next pixel of the current column.
// Result channel m_*: one pixel per tick while a span is active, with m_last
// on the final row. Ticks outside a span and start items give no result.
// Configuration: cfg_we writes cfg_wdata to register cfg_index (0 screen
// width, 1 screen height, 2 texture width, 3 texture height).
// Latency: a tick's result is on m_valid in the cycle after acceptance;
// ticks are taken one per cycle while the receiver keeps up.
// A start item holds s_ready low until the controller is idle again, through
// two passes of the shared radix-2 divider (slice height, then texture step).
// Reset: aresetn low for one clock clears the controller, the span and the
// output register and restores the register defaults 640, 480, 64, 64.
// Stall: while m_valid is high and m_ready low the result holds and
// s_ready stays low.
`default_nettype none

module textured_wall_column_core (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_we,
    input  wire logic [twc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [twc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic                              s_action,
    input  wire logic [twc_pkg::COL_W-1:0]         s_column_index,
    input  wire logic                              s_wall_side,
    input  wire logic signed [twc_pkg::RAY_W-1:0]  s_ray_x,
    input  wire logic signed [twc_pkg::RAY_W-1:0]  s_ray_y,
    input  wire logic [twc_pkg::DIST_W-1:0]        s_wall_distance,
    input  wire logic [twc_pkg::PLAYER_W-1:0]      s_player_x,
    input  wire logic [twc_pkg::PLAYER_W-1:0]      s_player_y,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [twc_pkg::SX_W-1:0]               m_screen_x,
    output logic [twc_pkg::SY_W-1:0]               m_screen_y,
    output logic [twc_pkg::TSEL_W-1:0]             m_texture_select,
    output logic [twc_pkg::TEXEL_W-1:0]            m_texel_column,
    output logic [twc_pkg::TEXEL_W-1:0]            m_texel_row,
    output logic                                   m_last
);
    import twc_pkg::*;

    twc_cmd_t    cmd;
    twc_status_t status;

    twc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_action (s_action),
        .status   (status),
        .s_ready  (s_ready),
        .cmd      (cmd)
    );

    twc_datapath u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .status           (status),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_column_index   (s_column_index),
        .s_wall_side      (s_wall_side),
        .s_ray_x          (s_ray_x),
        .s_ray_y          (s_ray_y),
        .s_wall_distance  (s_wall_distance),
        .s_player_x       (s_player_x),
        .s_player_y       (s_player_y),
        .m_ready          (m_ready),
        .m_valid          (m_valid),
        .m_screen_x       (m_screen_x),
        .m_screen_y       (m_screen_y),
        .m_texture_select (m_texture_select),
        .m_texel_column   (m_texel_column),
        .m_texel_row      (m_texel_row),
        .m_last           (m_last)
    );

endmodule

`default_nettype wire

FILE: hdl/twc_div.sv
`default_nettype none

module twc_div (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic [twc_pkg::DIV_W-1:0]    dividend,
    input  wire logic [twc_pkg::HEIGHT_W-1:0] divisor,
    output logic                            busy,
    output logic [twc_pkg::DIV_W-1:0]         quotient
);
    import twc_pkg::*;

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0]    quo_reg, quo_next;
    logic [HEIGHT_W-1:0] rem_reg, rem_next;
    logic [HEIGHT_W-1:0] dsor_reg, dsor_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic [HEIGHT_W:0]   trial;
    logic [HEIGHT_W:0]   diff;

    always_comb begin
        trial     = {rem_reg, quo_reg[DIV_W-1]};
        diff      = trial - {1'b0, dsor_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsor_next = dsor_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            dsor_next = divisor;
            cnt_next  = CNT_W'(DIV_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dsor_reg}) begin
                rem_next = diff[HEIGHT_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end else begin
                rem_next = trial[HEIGHT_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        dsor_reg <= dsor_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

FILE: hdl/twc_datapath.sv
`default_nettype none

module twc_datapath (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire twc_pkg::twc_cmd_t                 cmd,
    output twc_pkg::twc_status_t                   status,
    input  wire logic                              cfg_we,
    input  wire logic [twc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [twc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  wire logic [twc_pkg::COL_W-1:0]         s_column_index,
    input  wire logic                              s_wall_side,
    input  wire logic signed [twc_pkg::RAY_W-1:0]  s_ray_x,
    input  wire logic signed [twc_pkg::RAY_W-1:0]  s_ray_y,
    input  wire logic [twc_pkg::DIST_W-1:0]        s_wall_distance,
    input  wire logic [twc_pkg::PLAYER_W-1:0]      s_player_x,
    input  wire logic [twc_pkg::PLAYER_W-1:0]      s_player_y,
    input  wire logic                              m_ready,
    output logic                                   m_valid,
    output logic [twc_pkg::SX_W-1:0]               m_screen_x,
    output logic [twc_pkg::SY_W-1:0]               m_screen_y,
    output logic [twc_pkg::TSEL_W-1:0]             m_texture_select,
    output logic [twc_pkg::TEXEL_W-1:0]            m_texel_column,
    output logic [twc_pkg::TEXEL_W-1:0]            m_texel_row,
    output logic                                   m_last
);
    import twc_pkg::*;

    localparam int PROD1_W = DIST_W + 1 + RAY_W;
    localparam int PROD2_W = WALL_W + TW_W;
    localparam int PROD3_W = HHALF_W + STEP_W;

    logic [SW_W-1:0] screen_width_reg;
    logic [SH_W-1:0] screen_height_reg;
    logic [TW_W-1:0] texture_width_reg;
    logic [TH_W-1:0] texture_height_reg;

    logic                 span_active_reg;
    logic [ROW_W-1:0]     current_row_reg;
    logic [ROW_W-1:0]     end_row_reg;
    logic [POS_W-1:0]     texture_position_reg;
    logic [STEP_W-1:0]    texture_step_reg;
    logic [TSEL_W-1:0]    held_texture_reg;
    logic [TEXEL_W-1:0]   held_texel_column_reg;
    logic [SX_W-1:0]      held_screen_x_reg;

    logic [WALL_W-1:0]    prod1_reg;
    logic [FRAC_BITS-1:0] pos_low_reg;
    logic                 mirror_reg;
    logic [PROD2_W-1:0]   prod2_reg;
    logic [HEIGHT_W-1:0]  height_reg;
    logic [ROW_W-1:0]     ds_reg;
    logic [ROW_W-1:0]     de_reg;
    logic                 active_reg;
    logic [HHALF_W-1:0]   off_reg;

    logic                 m_valid_reg, m_valid_next;
    logic [SX_W-1:0]      m_screen_x_reg;
    logic [SY_W-1:0]      m_screen_y_reg;
    logic [TSEL_W-1:0]    m_texture_select_reg;
    logic [TEXEL_W-1:0]   m_texel_column_reg;
    logic [TEXEL_W-1:0]   m_texel_row_reg;
    logic                 m_last_reg;

    logic [PLAYER_W-1:0]       pos_sel;
    logic signed [RAY_W-1:0]   ray_sel;
    logic signed [PROD1_W-1:0] prod1;
    logic                      rx_pos, ry_pos, ry_neg;
    logic [TSEL_W-1:0]         tex_calc;
    logic [SW_W-1:0]           screen_x_calc;

    logic [WALL_W-1:0]    frac;
    logic [PROD2_W-1:0]   prod2;
    logic [TW_W-1:0]      tx;
    logic [TW_W-1:0]      texel_calc;

    logic                 div_start;
    logic [DIV_W-1:0]     div_dividend;
    logic [HEIGHT_W-1:0]  div_divisor;
    logic                 div_busy;
    logic [DIV_W-1:0]     div_quo;
    logic [HEIGHT_W-1:0]  height_sat;

    logic [HHALF_W-1:0]   sh_half;
    logic [HHALF_W-1:0]   h_half;
    logic                 h_over;
    logic [ROW_W-1:0]     ds_calc;
    logic [HHALF_W-1:0]   off_calc;
    logic [HEIGHT_W-1:0]  de_raw;
    logic [ROW_W-1:0]     de_calc;
    logic                 active_calc;

    logic [STEP_W-1:0]    step_calc;
    logic [PROD3_W-1:0]   pos_prod;

    logic                 emit;
    logic [TEXEL_W-1:0]   th_mask;
    logic                 last_calc;

    // start item: operand select and first product
    always_comb begin
        pos_sel       = s_wall_side ? s_player_x : s_player_y;
        ray_sel       = s_wall_side ? s_ray_x : s_ray_y;
        prod1         = $signed({1'b0, s_wall_distance}) * ray_sel;
        rx_pos        = !s_ray_x[RAY_W-1] && (s_ray_x != '0);
        ry_pos        = !s_ray_y[RAY_W-1] && (s_ray_y != '0);
        ry_neg        = s_ray_y[RAY_W-1];
        tex_calc      = s_wall_side ? (ry_pos ? TEX_NORTH : TEX_SOUTH)
                                    : (rx_pos ? TEX_WEST : TEX_EAST);
        screen_x_calc = screen_width_reg - SW_W'(s_column_index) - SW_W'(1);
    end

    // texel column from the wall hit fraction
    always_comb begin
        frac       = {pos_low_reg, {FRAC_BITS{1'b0}}} + prod1_reg;
        prod2      = frac * texture_width_reg;
        tx         = prod2_reg[WALL_W +: TW_W];
        texel_calc = mirror_reg ? (texture_width_reg - tx - TW_W'(1)) : tx;
    end

    // shared divider: slice height, then texture step
    always_comb begin
        div_start    = cmd.capture | cmd.take_height;
        div_dividend = cmd.capture ? {screen_height_reg, {FRAC_BITS{1'b0}}}
                                   : DIV_W'({texture_height_reg, {FRAC_BITS{1'b0}}});
        height_sat   = (div_quo > DIV_W'(HEIGHT_CAP)) ? HEIGHT_CAP
                                                      : div_quo[HEIGHT_W-1:0];
        div_divisor  = cmd.capture ? s_wall_distance : height_sat;
    end

    twc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    // row span from the height
    always_comb begin
        sh_half     = HHALF_W'(screen_height_reg[SH_W-1:1]);
        h_half      = height_reg[HEIGHT_W-1:1];
        h_over      = h_half > sh_half;
        ds_calc     = h_over ? '0 : ROW_W'(sh_half - h_half);
        off_calc    = h_over ? (h_half - sh_half) : '0;
        de_raw      = {1'b0, h_half} + HEIGHT_W'(sh_half);
        if (de_raw >= HEIGHT_W'(screen_height_reg)) begin
            de_calc = (screen_height_reg == '0) ? '0 : (screen_height_reg - ROW_W'(1));
        end else begin
            de_calc = de_raw[ROW_W-1:0];
        end
        active_calc = (screen_height_reg != '0) && (ds_calc < de_calc);
    end

    always_comb begin
        step_calc = (height_reg == '0) ? STEP_CAP : STEP_W'(div_quo);
        pos_prod  = off_reg * texture_step_reg;
    end

    // pixel ticks
    always_comb begin
        emit         = cmd.tick && span_active_reg;
        th_mask      = TEXEL_W'(texture_height_reg - TH_W'(1));
        last_calc    = ({1'b0, current_row_reg} + (ROW_W + 1)'(1))
                       >= {1'b0, end_row_reg};
        m_valid_next = m_valid_reg;
        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
        status.div_busy  = div_busy;
        status.out_stall = m_valid_reg && !m_ready;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            screen_width_reg   <= SW_W'(640);
            screen_height_reg  <= SH_W'(480);
            texture_width_reg  <= TW_W'(64);
            texture_height_reg <= TH_W'(64);
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_SCREEN_WIDTH:   screen_width_reg   <= cfg_wdata[SW_W-1:0];
                CFG_SCREEN_HEIGHT:  screen_height_reg  <= cfg_wdata[SH_W-1:0];
                CFG_TEXTURE_WIDTH:  texture_width_reg  <= cfg_wdata[TW_W-1:0];
                CFG_TEXTURE_HEIGHT: texture_height_reg <= cfg_wdata[TH_W-1:0];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            span_active_reg <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (cmd.commit) begin
                span_active_reg <= active_reg;
            end else if (emit && last_calc) begin
                span_active_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            prod1_reg         <= prod1[WALL_W-1:0];
            pos_low_reg       <= pos_sel[FRAC_BITS-1:0];
            mirror_reg        <= s_wall_side ? ry_neg : rx_pos;
            held_texture_reg  <= tex_calc;
            held_screen_x_reg <= screen_x_calc[SX_W-1:0];
        end
        if (cmd.tex_mul) begin
            prod2_reg <= prod2;
        end
        if (cmd.take_height) begin
            height_reg <= height_sat;
        end
        if (cmd.span_calc) begin
            ds_reg     <= ds_calc;
            de_reg     <= de_calc;
            active_reg <= active_calc;
            off_reg    <= off_calc;
        end
        if (cmd.take_step) begin
            texture_step_reg <= step_calc;
        end
        if (cmd.commit) begin
            texture_position_reg  <= pos_prod[POS_W-1:0];
            current_row_reg       <= ds_reg;
            end_row_reg           <= de_reg;
            held_texel_column_reg <= texel_calc[TEXEL_W-1:0];
        end
        if (emit) begin
            m_screen_x_reg       <= held_screen_x_reg;
            m_screen_y_reg       <= current_row_reg[SY_W-1:0];
            m_texture_select_reg <= held_texture_reg;
            m_texel_column_reg   <= held_texel_column_reg;
            m_texel_row_reg      <= texture_position_reg[FRAC_BITS +: TEXEL_W] & th_mask;
            m_last_reg           <= last_calc;
            texture_position_reg <= texture_position_reg + texture_step_reg;
            current_row_reg      <= current_row_reg + ROW_W'(1);
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_screen_x       = m_screen_x_reg;
    assign m_screen_y       = m_screen_y_reg;
    assign m_texture_select = m_texture_select_reg;
    assign m_texel_column   = m_texel_column_reg;
    assign m_texel_row      = m_texel_row_reg;
    assign m_last           = m_last_reg;

endmodule

`default_nettype wire

FILE: hdl/twc_ctrl.sv
`default_nettype none

module twc_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    input  wire logic                 s_action,
    input  wire twc_pkg::twc_status_t status,
    output logic                      s_ready,
    output twc_pkg::twc_cmd_t         cmd
);
    import twc_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_DIV_H  = 6'b000010,
        ST_HEIGHT = 6'b000100,
        ST_DIV_S  = 6'b001000,
        ST_STEP   = 6'b010000,
        ST_COMMIT = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    always_comb begin
        s_ready    = (state_reg == ST_IDLE) && !status.out_stall;
        accept     = s_valid && s_ready;
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_action == ACT_START) begin
                        cmd.capture = 1'b1;
                        state_next  = ST_DIV_H;
                    end else begin
                        cmd.tick = 1'b1;
                    end
                end
            end
            ST_DIV_H: begin
                cmd.tex_mul = 1'b1;
                if (!status.div_busy) begin
                    state_next = ST_HEIGHT;
                end
            end
            ST_HEIGHT: begin
                cmd.take_height = 1'b1;
                state_next      = ST_DIV_S;
            end
            ST_DIV_S: begin
                cmd.span_calc = 1'b1;
                if (!status.div_busy) begin
                    state_next = ST_STEP;
                end
            end
            ST_STEP: begin
                cmd.take_step = 1'b1;
                state_next    = ST_COMMIT;
            end
            ST_COMMIT: begin
                cmd.commit = 1'b1;
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/twc_props.sv
`default_nettype none

module twc_props (
    input wire logic                        aclk,
    input wire logic                        aresetn,
    input wire logic                        s_valid,
    input wire logic                        s_ready,
    input wire logic                        s_action,
    input wire logic                        m_valid,
    input wire logic                        m_ready,
    input wire logic [twc_pkg::SY_W-1:0]    m_screen_y,
    input wire logic                        m_last
);
    import twc_pkg::*;

    property p_out_hold;
        @(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_screen_y) && $stable(m_last));
    endproperty
    a_out_hold: assert property (p_out_hold)
        else $error("result changed while stalled");

    property p_no_accept_on_stall;
        @(posedge aclk) disable iff (!aresetn)
        s_ready |-> (!m_valid || m_ready);
    endproperty
    a_no_accept_on_stall: assert property (p_no_accept_on_stall)
        else $error("input ready while result stalled");

    property p_start_no_result;
        @(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_action == ACT_START) && (!m_valid || m_ready))
            |=> !m_valid;
    endproperty
    a_start_no_result: assert property (p_start_no_result)
        else $error("start item produced a result");

    property p_start_busy;
        @(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_action == ACT_START)) |=> !s_ready;
    endproperty
    a_start_busy: assert property (p_start_busy)
        else $error("input ready right after a start item");

endmodule

bind textured_wall_column_core twc_props u_props (.*);

`default_nettype wire

FILE: sim/wall_pixel_checker.sv
`timescale 1ns / 1ps

module wall_pixel_checker
    import twc_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_wdata,
    input  logic                        s_valid,
    input  logic                        s_ready,
    input  logic                        s_action,
    input  logic [COL_W-1:0]            s_column_index,
    input  logic                        s_wall_side,
    input  logic signed [RAY_W-1:0]     s_ray_x,
    input  logic signed [RAY_W-1:0]     s_ray_y,
    input  logic [DIST_W-1:0]           s_wall_distance,
    input  logic [PLAYER_W-1:0]         s_player_x,
    input  logic [PLAYER_W-1:0]         s_player_y,
    input  logic                        m_valid,
    input  logic                        m_ready,
    input  logic [SX_W-1:0]             m_screen_x,
    input  logic [SY_W-1:0]             m_screen_y,
    input  logic [TSEL_W-1:0]           m_texture_select,
    input  logic [TEXEL_W-1:0]          m_texel_column,
    input  logic [TEXEL_W-1:0]          m_texel_row,
    input  logic                        m_last,
    output int                          mismatch_count,
    output int                          pending_pixels,
    output int                          counted_items
);

    localparam longint HEIGHT_MAX = longint'(HEIGHT_CAP);
    localparam longint STEP_MAX   = longint'(STEP_CAP);

    typedef struct {
        logic [SX_W-1:0]    sx;
        logic [SY_W-1:0]    sy;
        logic [TSEL_W-1:0]  tsel;
        logic [TEXEL_W-1:0] tcol;
        logic [TEXEL_W-1:0] trow;
        logic               last;
    } pixel_t;

    pixel_t pixels_due[$];
    int fails = 0;
    int useful = 0;

    logic [SW_W-1:0]    cfg_sw;
    logic [SH_W-1:0]    cfg_sh;
    logic [TW_W-1:0]    cfg_tw;
    logic [TH_W-1:0]    cfg_th;

    logic               span_on;
    logic [31:0]        row_now;
    logic [31:0]        row_end;
    logic [POS_W-1:0]   tex_pos;
    logic [STEP_W-1:0]  tex_step;
    logic [TSEL_W-1:0]  tex_sel;
    logic [TEXEL_W-1:0] tex_col;
    logic [SX_W-1:0]    col_x;

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch at %0t: %s is %0d, expected %0d", $time, what, got, want);
        fails++;
    endtask

    task automatic begin_column(input logic [COL_W-1:0] col, input logic side,
                                input logic signed [RAY_W-1:0] rx,
                                input logic signed [RAY_W-1:0] ry,
                                input logic [DIST_W-1:0] wall_dist,
                                input logic [PLAYER_W-1:0] px,
                                input logic [PLAYER_W-1:0] py);
        longint rows, half_rows, hgt, half_hgt, first, stop, base, slope, off, step, prod;
        logic [63:0] hit, tcol_wide;
        logic [31:0] sx_wide;
        logic flip;
        rows = longint'(cfg_sh);
        if (wall_dist == '0) begin
            hgt = HEIGHT_MAX;
        end else begin
            hgt = (rows << FRAC_BITS) / longint'(wall_dist);
            if (hgt > HEIGHT_MAX) hgt = HEIGHT_MAX;
        end
        half_rows = rows / 2;
        half_hgt = hgt / 2;
        first = half_rows - half_hgt;
        if (first < 0) first = 0;
        stop = half_hgt + half_rows;
        if (stop >= rows) stop = rows - 1;

        if (!side) begin
            tex_sel = (rx > 0) ? TEX_WEST : TEX_EAST;
            base = longint'(py);
            slope = longint'(ry);
        end else begin
            tex_sel = (ry > 0) ? TEX_NORTH : TEX_SOUTH;
            base = longint'(px);
            slope = longint'(rx);
        end
        hit = (base << FRAC_BITS) + longint'(wall_dist) * slope;
        tcol_wide = (64'(hit[WALL_W-1:0]) * 64'(cfg_tw)) >> WALL_W;
        flip = (!side && rx > 0) || (side && ry < 0);
        if (flip) tcol_wide = 64'(cfg_tw) - tcol_wide - 64'd1;
        tex_col = tcol_wide[TEXEL_W-1:0];

        if (hgt == 0) begin
            step = STEP_MAX;
        end else begin
            step = (longint'(cfg_th) << FRAC_BITS) / hgt;
            if (step > STEP_MAX) step = STEP_MAX;
        end
        tex_step = step[STEP_W-1:0];
        off = first - half_rows + half_hgt;
        prod = off * step;
        tex_pos = prod[POS_W-1:0];

        sx_wide = 32'(cfg_sw) - 32'(col) - 32'd1;
        col_x = sx_wide[SX_W-1:0];
        row_now = first[31:0];
        row_end = (stop > 0) ? stop[31:0] : '0;
        span_on = first < stop;
    endtask

    task automatic next_pixel();
        pixel_t px_e;
        logic [31:0] row_mask, tex_int;
        if (!span_on) return;
        row_mask = (32'(cfg_th) - 32'd1) & 32'h7FF;
        tex_int = (tex_pos >> FRAC_BITS) & row_mask;
        px_e.sx = col_x;
        px_e.sy = row_now[SY_W-1:0];
        px_e.tsel = tex_sel;
        px_e.tcol = tex_col;
        px_e.trow = tex_int[TEXEL_W-1:0];
        px_e.last = (row_now + 32'd1) >= row_end;
        pixels_due.push_back(px_e);
        tex_pos = tex_pos + tex_step;
        row_now = row_now + 32'd1;
        if (px_e.last) span_on = 1'b0;
    endtask

    always @(posedge aclk) begin
        pixel_t want;
        if (!aresetn) begin
            cfg_sw = 640;
            cfg_sh = 480;
            cfg_tw = 64;
            cfg_th = 64;
            span_on = 1'b0;
            row_now = '0;
            row_end = '0;
            tex_pos = '0;
            tex_step = '0;
            tex_sel = '0;
            tex_col = '0;
            col_x = '0;
            pixels_due.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_SCREEN_WIDTH:   cfg_sw = cfg_wdata[SW_W-1:0];
                    CFG_SCREEN_HEIGHT:  cfg_sh = cfg_wdata[SH_W-1:0];
                    CFG_TEXTURE_WIDTH:  cfg_tw = cfg_wdata[TW_W-1:0];
                    CFG_TEXTURE_HEIGHT: cfg_th = cfg_wdata[TH_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                useful++;
                if (s_action == ACT_START) begin
                    begin_column(s_column_index, s_wall_side, s_ray_x, s_ray_y,
                                 s_wall_distance, s_player_x, s_player_y);
                end else begin
                    next_pixel();
                end
            end
            if (m_valid && m_ready) begin
                if (pixels_due.size() == 0) begin
                    report("pixel with none due, screen_y", m_screen_y, -1);
                end else begin
                    want = pixels_due.pop_front();
                    if (m_screen_x !== want.sx) report("screen_x", m_screen_x, want.sx);
                    if (m_screen_y !== want.sy) report("screen_y", m_screen_y, want.sy);
                    if (m_texture_select !== want.tsel)
                        report("texture_select", m_texture_select, want.tsel);
                    if (m_texel_column !== want.tcol)
                        report("texel_column", m_texel_column, want.tcol);
                    if (m_texel_row !== want.trow) report("texel_row", m_texel_row, want.trow);
                    if (m_last !== want.last) report("last", m_last, want.last);
                end
            end
        end
        mismatch_count <= fails;
        pending_pixels <= pixels_due.size();
        counted_items <= useful;
    end

endmodule

FILE: sim/textured_wall_column_core_test.sv
`timescale 1ns / 1ps

module textured_wall_column_core_test;
    import twc_pkg::*;

    localparam int CYCLE_LIMIT = 900000;
    localparam int PHASE_ITEMS = 300;

    logic                       aclk;
    logic                       aresetn;
    logic                       cfg_we;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [CFG_DATA_W-1:0]      cfg_wdata;
    logic                       s_valid;
    logic                       s_ready;
    logic                       s_action;
    logic [COL_W-1:0]           s_column_index;
    logic                       s_wall_side;
    logic signed [RAY_W-1:0]    s_ray_x;
    logic signed [RAY_W-1:0]    s_ray_y;
    logic [DIST_W-1:0]          s_wall_distance;
    logic [PLAYER_W-1:0]        s_player_x;
    logic [PLAYER_W-1:0]        s_player_y;
    logic                       m_valid;
    logic                       m_ready;
    logic [SX_W-1:0]            m_screen_x;
    logic [SY_W-1:0]            m_screen_y;
    logic [TSEL_W-1:0]          m_texture_select;
    logic [TEXEL_W-1:0]         m_texel_column;
    logic [TEXEL_W-1:0]         m_texel_row;
    logic                       m_last;

    int mismatch_count;
    int pending_pixels;
    int counted_items;

    bit calm = 1'b0;
    bit want_hold = 1'b0;
    bit hold_done = 1'b0;
    int unsigned rows_full = 480;

    textured_wall_column_core dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_action         (s_action),
        .s_column_index   (s_column_index),
        .s_wall_side      (s_wall_side),
        .s_ray_x          (s_ray_x),
        .s_ray_y          (s_ray_y),
        .s_wall_distance  (s_wall_distance),
        .s_player_x       (s_player_x),
        .s_player_y       (s_player_y),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_screen_x       (m_screen_x),
        .m_screen_y       (m_screen_y),
        .m_texture_select (m_texture_select),
        .m_texel_column   (m_texel_column),
        .m_texel_row      (m_texel_row),
        .m_last           (m_last)
    );

    wall_pixel_checker u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_action         (s_action),
        .s_column_index   (s_column_index),
        .s_wall_side      (s_wall_side),
        .s_ray_x          (s_ray_x),
        .s_ray_y          (s_ray_y),
        .s_wall_distance  (s_wall_distance),
        .s_player_x       (s_player_x),
        .s_player_y       (s_player_y),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_screen_x       (m_screen_x),
        .m_screen_y       (m_screen_y),
        .m_texture_select (m_texture_select),
        .m_texel_column   (m_texel_column),
        .m_texel_row      (m_texel_row),
        .m_last           (m_last),
        .mismatch_count   (mismatch_count),
        .pending_pixels   (pending_pixels),
        .counted_items    (counted_items)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    function automatic logic [DIST_W-1:0] pick_distance(input int unsigned rows);
        longint num, d;
        int unsigned h;
        logic [31:0] r;
        num = longint'(rows) << FRAC_BITS;
        r = $urandom;
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4: return r[DIST_W-1:0];
            5, 6: return DIST_W'($urandom_range(0, 300));
            default: begin
                h = $urandom_range(0, 40);
                if (h == 0) begin
                    d = num + $urandom_range(1, 1000);
                end else begin
                    d = num / h;
                    if (d > 3) d = d - $urandom_range(0, 3);
                end
                if (d > 64'hFFFFFF) d = 64'hFFFFFF;
                return d[DIST_W-1:0];
            end
        endcase
    endfunction

    task automatic offer(input logic act, input logic [COL_W-1:0] col, input logic side,
                         input logic [RAY_W-1:0] rx, input logic [RAY_W-1:0] ry,
                         input logic [DIST_W-1:0] wall_dist,
                         input logic [PLAYER_W-1:0] px, input logic [PLAYER_W-1:0] py);
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_action <= act;
        s_column_index <= col;
        s_wall_side <= side;
        s_ray_x <= rx;
        s_ray_y <= ry;
        s_wall_distance <= wall_dist;
        s_player_x <= px;
        s_player_y <= py;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic offer_tick();
        logic [31:0] a, b, c, d;
        a = $urandom;
        b = $urandom;
        c = $urandom;
        d = $urandom;
        offer(ACT_TICK, a[COL_W-1:0], a[31], b[RAY_W-1:0], c[RAY_W-1:0],
              d[DIST_W-1:0], b[31:8], c[31:8]);
    endtask

    task automatic offer_column();
        logic [31:0] a, b, c, d, e;
        logic [RAY_W-1:0] rx, ry;
        a = $urandom;
        b = $urandom;
        c = $urandom;
        d = $urandom;
        e = $urandom;
        rx = ($urandom_range(0, 15) == 0) ? '0 : b[RAY_W-1:0];
        ry = ($urandom_range(0, 15) == 0) ? '0 : c[RAY_W-1:0];
        offer(ACT_START, a[COL_W-1:0], a[31], rx, ry, pick_distance(rows_full),
              d[PLAYER_W-1:0], e[PLAYER_W-1:0]);
    endtask

    task automatic run_columns(input int goal);
        int base;
        base = counted_items;
        while (counted_items - base < goal) begin
            if ($urandom_range(0, 9) == 0) begin
                offer_tick();
            end else begin
                offer_column();
                repeat ($urandom_range(0, 48)) offer_tick();
            end
        end
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_pixels != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    task automatic set_registers(input int unsigned sw, input int unsigned sh,
                                 input int unsigned tw, input int unsigned th);
        cfg_we <= 1'b1;
        cfg_index <= CFG_SCREEN_WIDTH;
        cfg_wdata <= sw[CFG_DATA_W-1:0];
        @(posedge aclk);
        cfg_index <= CFG_SCREEN_HEIGHT;
        cfg_wdata <= sh[CFG_DATA_W-1:0];
        @(posedge aclk);
        cfg_index <= CFG_TEXTURE_WIDTH;
        cfg_wdata <= tw[CFG_DATA_W-1:0];
        @(posedge aclk);
        cfg_index <= CFG_TEXTURE_HEIGHT;
        cfg_wdata <= th[CFG_DATA_W-1:0];
        @(posedge aclk);
        cfg_we <= 1'b0;
        rows_full = sh & 32'hFFF;
    endtask

    initial begin
        m_ready = 1'b0;
        @(posedge aclk);
        forever begin
            if (want_hold && !hold_done) begin
                m_ready <= 1'b0;
                repeat (400) @(posedge aclk);
                hold_done = 1'b1;
            end else if (!calm && $urandom_range(0, 6) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge aclk);
            end
        end
    end

    initial begin
        int unsigned cycles_run;
        cycles_run = 0;
        while (cycles_run < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles_run++;
        end
        $display("Verification failed");
        $finish;
    end

    initial begin
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_action = 1'b0;
        s_column_index = '0;
        s_wall_side = 1'b0;
        s_ray_x = '0;
        s_ray_y = '0;
        s_wall_distance = '0;
        s_player_x = '0;
        s_player_y = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        offer(ACT_START, 12'd0, 1'b0, 18'h1FFFF, 18'h20000, 24'd0, 24'd0, 24'hFFFFFF);
        repeat (3) offer_tick();
        offer(ACT_START, 12'hFFF, 1'b1, 18'h20000, 18'h1FFFF, 24'hFFFFFF, 24'hFFFFFF, 24'd0);
        offer_tick();
        offer(ACT_START, 12'd100, 1'b1, 18'd30000, 18'h3EC78, 24'd7864320,
              24'h123456, 24'h0ABCDE);
        repeat (6) offer_tick();
        offer(ACT_START, 12'd639, 1'b0, 18'd0, 18'd0, 24'd5242880, 24'h3A0000, 24'h018000);
        repeat (7) offer_tick();
        offer(ACT_START, 12'd320, 1'b1, 18'h20000, 18'd0, 24'd1, 24'h800001, 24'h7FFFFF);
        repeat (2) offer_tick();

        run_columns(PHASE_ITEMS);
        settle();
        set_registers(4096, 2048, 1024, 1024);
        want_hold = 1'b1;
        run_columns(PHASE_ITEMS);
        settle();
        set_registers(1, 1, 1, 1);
        run_columns(PHASE_ITEMS);
        settle();
        set_registers(8191, 4095, 2047, 2047);
        run_columns(PHASE_ITEMS);
        settle();
        set_registers(0, 0, 0, 0);
        run_columns(PHASE_ITEMS);
        settle();
        calm = 1'b1;
        set_registers($urandom_range(1, 4096), $urandom_range(16, 2048),
                      $urandom_range(1, 1024), 1 << $urandom_range(0, 10));
        run_columns(PHASE_ITEMS);
        settle();

        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hdl/twc_pkg.sv
hdl/twc_div.sv
hdl/twc_datapath.sv
hdl/twc_ctrl.sv
hdl/textured_wall_column_core.sv
hdl/twc_props.sv
sim/wall_pixel_checker.sv
sim/textured_wall_column_core_test.sv
